### sv/ild_pkg.sv
package ild_pkg;

  // Longest legal instruction in bytes
  localparam int unsigned MAX_INSTR_BYTES_DEF = 15;

  // Byte counter width, sized for the architectural maximum
  localparam int unsigned CNT_W = 4;

  // Immediate codes carried from opcode to ModRM for group F6/F7
  localparam logic [2:0] IMM_TEST_B = 3'd5;
  localparam logic [2:0] IMM_TEST_Z = 3'd6;

  // Opcode bytes with special meaning
  localparam logic [7:0] OPC_ESC     = 8'h0F;
  localparam logic [7:0] OPC_OPSIZE  = 8'h66;
  localparam logic [7:0] OPC_ADSIZE  = 8'h67;
  localparam logic [7:0] OPC_ESC38   = 8'h38;
  localparam logic [7:0] OPC_ESC3A   = 8'h3A;
  localparam logic [7:0] OPC_GRP3B   = 8'hF6;
  localparam logic [7:0] OPC_GRP3Z   = 8'hF7;
  localparam logic [7:0] OPC_VEX3    = 8'hC4;
  localparam logic [7:0] OPC_VEX2    = 8'hC5;

  // ModRM / SIB field codes
  localparam logic [1:0] MOD_REG     = 2'b11;
  localparam logic [2:0] RM_SIB      = 3'b100;
  localparam logic [2:0] RM_DISP32   = 3'b101;
  localparam logic [2:0] RM_DISP16   = 3'b110;

  // Decode phase, one-hot
  typedef enum logic [7:0] {
    PH_OPCODE = 8'b0000_0001,
    PH_VEX    = 8'b0000_0010,
    PH_MAP0F  = 8'b0000_0100,
    PH_MAP38  = 8'b0000_1000,
    PH_MAP3A  = 8'b0001_0000,
    PH_MODRM  = 8'b0010_0000,
    PH_SIB    = 8'b0100_0000,
    PH_TAIL   = 8'b1000_0000
  } phase_t;

  // Per-instruction decode state
  typedef struct packed {
    phase_t           phase;
    logic             operand_is_16;
    logic             operand_is_64;
    logic             address_is_16;
    logic [CNT_W-1:0] bytes_counted;
    logic [3:0]       bytes_to_skip;
    logic [2:0]       imm_after_modrm;
    logic [7:0]       held_opcode;
  } ild_state_t;

  localparam ild_state_t STATE_CLEAR = '{
    phase:           PH_OPCODE,
    operand_is_16:   1'b0,
    operand_is_64:   1'b0,
    address_is_16:   1'b0,
    bytes_counted:   '0,
    bytes_to_skip:   4'd0,
    imm_after_modrm: 3'd0,
    held_opcode:     8'd0
  };

  // Result of one decode step
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] instr_length;
    logic             overlong;
  } ild_result_t;

endpackage

### sv/ild_step.sv
module ild_step #(
  parameter int unsigned MAX_INSTR_BYTES = ild_pkg::MAX_INSTR_BYTES_DEF
) (
  input  ild_pkg::ild_state_t  state,
  input  logic [7:0]           code_byte,
  input  logic                 long_mode,
  output ild_pkg::ild_state_t  state_nxt,
  output ild_pkg::ild_result_t result
);

  localparam logic [ild_pkg::CNT_W-1:0] MAX_CNT = ild_pkg::CNT_W'(MAX_INSTR_BYTES);

  function automatic logic rng(input logic [7:0] v, input logic [7:0] lo,
                               input logic [7:0] hi);
    rng = (v >= lo) && (v <= hi);
  endfunction

  logic [ild_pkg::CNT_W-1:0] n;
  logic                      done;
  ild_pkg::ild_state_t       st;
  logic [4:0]                sz_iz;
  logic [4:0]                sz_iv;
  logic [4:0]                sz_addr;
  logic [4:0]                rem;
  logic                      want_modrm;
  logic                      want_tail;
  logic [2:0]                imm_code;
  logic [4:0]                imm;
  logic [4:0]                disp;
  logic [1:0]                mrm_mod;
  logic [2:0]                mrm_rm;
  logic [2:0]                mrm_reg;
  logic                      is_prefix;

  // Operand and address sizes of the instruction in flight
  always_comb begin
    sz_iz = (state.operand_is_16 && !state.operand_is_64) ? 5'd2 : 5'd4;
    if (state.operand_is_64) begin
      sz_iv = 5'd8;
    end else begin
      sz_iv = state.operand_is_16 ? 5'd2 : 5'd4;
    end
    if (long_mode) begin
      sz_addr = state.address_is_16 ? 5'd4 : 5'd8;
    end else begin
      sz_addr = state.address_is_16 ? 5'd2 : 5'd4;
    end
  end

  assign mrm_mod = code_byte[7:6];
  assign mrm_rm  = code_byte[2:0];
  assign mrm_reg = code_byte[5:3];
  assign n       = state.bytes_counted + 1'b1;

  assign is_prefix = (code_byte == 8'h26) || (code_byte == 8'h2E) ||
                     (code_byte == 8'h36) || (code_byte == 8'h3E) ||
                     (code_byte == 8'h64) || (code_byte == 8'h65) ||
                     (code_byte == 8'hF2) || (code_byte == 8'hF3);

  // Advance the decode state by one byte
  always_comb begin
    st         = state;
    done       = 1'b0;
    want_modrm = 1'b0;
    want_tail  = 1'b0;
    imm_code   = 3'd0;
    rem        = 5'd0;
    imm        = 5'd0;
    disp       = 5'd0;

    case (state.phase)
      ild_pkg::PH_OPCODE: begin
        st.held_opcode = code_byte;
        if (code_byte == ild_pkg::OPC_ESC) begin
          st.phase = ild_pkg::PH_MAP0F;
        end else if (code_byte == ild_pkg::OPC_OPSIZE) begin
          st.operand_is_16 = 1'b1;
        end else if (code_byte == ild_pkg::OPC_ADSIZE) begin
          st.address_is_16 = 1'b1;
        end else if (is_prefix) begin
          st.phase = state.phase;
        end else if (long_mode && rng(code_byte, 8'h40, 8'h4F)) begin
          if (code_byte[3]) begin
            st.operand_is_64 = 1'b1;
          end
        end else if (code_byte == ild_pkg::OPC_VEX3 || code_byte == ild_pkg::OPC_VEX2) begin
          if (long_mode) begin
            st.bytes_to_skip = (code_byte == ild_pkg::OPC_VEX3) ? 4'd2 : 4'd1;
            st.phase         = ild_pkg::PH_VEX;
          end else begin
            want_modrm = 1'b1;
          end
        end else if (code_byte < 8'h40) begin
          if (code_byte[2] == 1'b0) begin
            want_modrm = 1'b1;
          end else if (code_byte[2:0] == 3'd4) begin
            want_tail = 1'b1;
            rem       = 5'd1;
          end else if (code_byte[2:0] == 3'd5) begin
            want_tail = 1'b1;
            rem       = sz_iz;
          end else begin
            done = 1'b1;
          end
        end else if (code_byte == 8'h62 || code_byte == 8'h63 ||
                     rng(code_byte, 8'h84, 8'h8F) || rng(code_byte, 8'hD0, 8'hD3) ||
                     code_byte == 8'hFE || code_byte == 8'hFF) begin
          want_modrm = 1'b1;
        end else if (code_byte == 8'h6A || rng(code_byte, 8'h70, 8'h7F) ||
                     code_byte == 8'hA8 || rng(code_byte, 8'hB0, 8'hB7) ||
                     code_byte == 8'hCD || code_byte == 8'hD4 || code_byte == 8'hD5 ||
                     rng(code_byte, 8'hE0, 8'hE7) || code_byte == 8'hEB) begin
          want_tail = 1'b1;
          rem       = 5'd1;
        end else if (code_byte == 8'h68 || code_byte == 8'hA9 ||
                     code_byte == 8'hE8 || code_byte == 8'hE9) begin
          want_tail = 1'b1;
          rem       = sz_iz;
        end else if (code_byte == 8'h69 || code_byte == 8'h81 || code_byte == 8'hC7) begin
          want_modrm = 1'b1;
          imm_code   = sz_iz[2:0];
        end else if (code_byte == 8'h6B || code_byte == 8'h80 || code_byte == 8'h82 ||
                     code_byte == 8'h83 || code_byte == 8'hC0 || code_byte == 8'hC1 ||
                     code_byte == 8'hC6) begin
          want_modrm = 1'b1;
          imm_code   = 3'd1;
        end else if (rng(code_byte, 8'hA0, 8'hA3)) begin
          want_tail = 1'b1;
          rem       = sz_addr;
        end else if (rng(code_byte, 8'hB8, 8'hBF)) begin
          want_tail = 1'b1;
          rem       = sz_iv;
        end else if (code_byte == 8'hC2 || code_byte == 8'hCA) begin
          want_tail = 1'b1;
          rem       = 5'd2;
        end else if (code_byte == 8'hC8) begin
          want_tail = 1'b1;
          rem       = 5'd3;
        end else if (code_byte == 8'h9A || code_byte == 8'hEA) begin
          want_tail = 1'b1;
          rem       = 5'd2 + sz_iz;
        end else if (code_byte == ild_pkg::OPC_GRP3B) begin
          want_modrm = 1'b1;
          imm_code   = ild_pkg::IMM_TEST_B;
        end else if (code_byte == ild_pkg::OPC_GRP3Z) begin
          want_modrm = 1'b1;
          imm_code   = ild_pkg::IMM_TEST_Z;
        end else begin
          done = 1'b1;
        end
      end

      ild_pkg::PH_VEX: begin
        if (state.bytes_to_skip <= 4'd1) begin
          st.bytes_to_skip = 4'd0;
          st.phase         = ild_pkg::PH_OPCODE;
        end else begin
          st.bytes_to_skip = state.bytes_to_skip - 4'd1;
        end
      end

      ild_pkg::PH_MAP0F: begin
        st.held_opcode = code_byte;
        if (code_byte == ild_pkg::OPC_ESC38) begin
          st.phase = ild_pkg::PH_MAP38;
        end else if (code_byte == ild_pkg::OPC_ESC3A) begin
          st.phase = ild_pkg::PH_MAP3A;
        end else if (rng(code_byte, 8'h80, 8'h8F)) begin
          want_tail = 1'b1;
          rem       = sz_iz;
        end else if (rng(code_byte, 8'h70, 8'h73) || code_byte == 8'hA4 ||
                     code_byte == 8'hAC || code_byte == 8'hBA || code_byte == 8'hC2 ||
                     rng(code_byte, 8'hC4, 8'hC6)) begin
          want_modrm = 1'b1;
          imm_code   = 3'd1;
        end else if (rng(code_byte, 8'h00, 8'h03) || code_byte == 8'h0D ||
                     rng(code_byte, 8'h10, 8'h18) || code_byte == 8'h1A ||
                     code_byte == 8'h1B || code_byte == 8'h1F ||
                     rng(code_byte, 8'h20, 8'h23) || rng(code_byte, 8'h28, 8'h2F) ||
                     rng(code_byte, 8'h40, 8'h6F) || rng(code_byte, 8'h74, 8'h76) ||
                     code_byte == 8'h78 || code_byte == 8'h79 ||
                     rng(code_byte, 8'h7C, 8'h7F) || rng(code_byte, 8'h90, 8'h9F) ||
                     code_byte == 8'hA3 || code_byte == 8'hA5 ||
                     rng(code_byte, 8'hAB, 8'hAF) || rng(code_byte, 8'hB0, 8'hB8) ||
                     rng(code_byte, 8'hBB, 8'hBF) || code_byte == 8'hC0 ||
                     code_byte == 8'hC1 || code_byte == 8'hC3 || code_byte == 8'hC7 ||
                     rng(code_byte, 8'hD0, 8'hFE)) begin
          want_modrm = 1'b1;
        end else begin
          done = 1'b1;
        end
      end

      ild_pkg::PH_MAP38: begin
        st.held_opcode = code_byte;
        if (code_byte == 8'h10 || code_byte == 8'h13) begin
          want_modrm = 1'b1;
          imm_code   = 3'd1;
        end else if (rng(code_byte, 8'h00, 8'h0F) || rng(code_byte, 8'h14, 8'h1A) ||
                     rng(code_byte, 8'h1C, 8'h1E) || rng(code_byte, 8'h20, 8'h25) ||
                     rng(code_byte, 8'h28, 8'h41) || rng(code_byte, 8'h45, 8'h47) ||
                     rng(code_byte, 8'h58, 8'h5A) || code_byte == 8'h78 ||
                     code_byte == 8'h79 || rng(code_byte, 8'h80, 8'h82) ||
                     code_byte == 8'h8C || code_byte == 8'h8E ||
                     rng(code_byte, 8'h90, 8'h93) || rng(code_byte, 8'h96, 8'h9F) ||
                     rng(code_byte, 8'hA6, 8'hAF) || rng(code_byte, 8'hB6, 8'hBF) ||
                     rng(code_byte, 8'hC8, 8'hCD) || rng(code_byte, 8'hDB, 8'hDF) ||
                     rng(code_byte, 8'hF0, 8'hF3) || rng(code_byte, 8'hF5, 8'hF7)) begin
          want_modrm = 1'b1;
        end else begin
          done = 1'b1;
        end
      end

      ild_pkg::PH_MAP3A: begin
        st.held_opcode = code_byte;
        if (rng(code_byte, 8'h00, 8'h02) || rng(code_byte, 8'h04, 8'h06) ||
            rng(code_byte, 8'h08, 8'h0F) || rng(code_byte, 8'h14, 8'h19) ||
            code_byte == 8'h1D || rng(code_byte, 8'h20, 8'h22) ||
            code_byte == 8'h38 || code_byte == 8'h39 ||
            rng(code_byte, 8'h40, 8'h42) || code_byte == 8'h44 ||
            code_byte == 8'h46 || rng(code_byte, 8'h4A, 8'h4C) ||
            rng(code_byte, 8'h60, 8'h63) || code_byte == 8'hCC ||
            code_byte == 8'hDF || code_byte == 8'hF0) begin
          want_modrm = 1'b1;
          imm_code   = 3'd1;
        end else begin
          done = 1'b1;
        end
      end

      ild_pkg::PH_MODRM: begin
        st.held_opcode = code_byte;
        // Resolve the group F6/F7 immediate from the reg field
        if (state.imm_after_modrm == ild_pkg::IMM_TEST_B) begin
          imm = (mrm_reg == 3'd0) ? 5'd1 : 5'd0;
        end else if (state.imm_after_modrm == ild_pkg::IMM_TEST_Z) begin
          imm = (mrm_reg == 3'd0) ? sz_iz : 5'd0;
        end else if (state.imm_after_modrm > 3'd4) begin
          imm = 5'd0;
        end else begin
          imm = {2'b00, state.imm_after_modrm};
        end
        if (mrm_mod == ild_pkg::MOD_REG) begin
          want_tail = 1'b1;
          rem       = imm;
        end else if (!long_mode && state.address_is_16) begin
          if (mrm_mod == 2'd1) begin
            disp = 5'd1;
          end else if (mrm_mod == 2'd2 || mrm_rm == ild_pkg::RM_DISP16) begin
            disp = 5'd2;
          end
          want_tail = 1'b1;
          rem       = disp + imm;
        end else begin
          if (mrm_mod == 2'd1) begin
            disp = 5'd1;
          end else if (mrm_mod == 2'd2 || mrm_rm == ild_pkg::RM_DISP32) begin
            disp = 5'd4;
          end
          if (mrm_rm == ild_pkg::RM_SIB) begin
            rem              = disp + imm;
            st.bytes_to_skip = rem[3:0];
            st.phase         = ild_pkg::PH_SIB;
          end else begin
            want_tail = 1'b1;
            rem       = disp + imm;
          end
        end
      end

      ild_pkg::PH_SIB: begin
        // SIB base 101 under mod 00 brings a disp32
        rem = {1'b0, state.bytes_to_skip};
        if (state.held_opcode[7:6] == 2'b00 && code_byte[2:0] == ild_pkg::RM_DISP32) begin
          rem = rem + 5'd4;
        end
        want_tail = 1'b1;
      end

      default: begin
        if (state.bytes_to_skip <= 4'd1) begin
          done = 1'b1;
        end else begin
          st.bytes_to_skip = state.bytes_to_skip - 4'd1;
        end
      end
    endcase

    if (want_modrm) begin
      st.imm_after_modrm = imm_code;
      st.phase           = ild_pkg::PH_MODRM;
    end
    if (want_tail) begin
      if (rem == 5'd0) begin
        done = 1'b1;
      end else begin
        st.bytes_to_skip = rem[3:0];
        st.phase         = ild_pkg::PH_TAIL;
      end
    end
  end

  // Close the instruction on its last byte or at the length limit
  always_comb begin
    state_nxt           = st;
    result.valid        = 1'b0;
    result.instr_length = n;
    result.overlong     = 1'b0;
    if (done) begin
      result.valid = 1'b1;
      state_nxt    = ild_pkg::STATE_CLEAR;
    end else if (n >= MAX_CNT) begin
      result.valid        = 1'b1;
      result.instr_length = MAX_CNT;
      result.overlong     = 1'b1;
      state_nxt           = ild_pkg::STATE_CLEAR;
    end else begin
      state_nxt.bytes_counted = n;
    end
  end

endmodule

### sv/x86_instruction_length_decoder_core.sv
// A byte accepted into the byte register is decoded combinationally; its result (if any)
// goes to the out_ ports through the result register once that is free or being taken.
// Throughput: one byte per cycle unless the result register is stalled; the single
// decode step between the byte register and the result register sets that figure.
// Reset: synchronous active-low rst_n clears decode state, both valid flags and
// long_mode.
module x86_instruction_length_decoder_core #(
  parameter int unsigned MAX_INSTR_BYTES = ild_pkg::MAX_INSTR_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_code_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_instr_length,
  output logic       out_overlong
);

  logic                 long_mode_r;
  logic                 in_valid_r;
  logic [7:0]           in_code_byte_r;
  ild_pkg::ild_state_t  state_r;
  ild_pkg::ild_state_t  state_nxt;
  ild_pkg::ild_result_t step_res;
  logic                 out_valid_r;
  logic [3:0]           out_instr_length_r;
  logic                 out_overlong_r;
  logic                 advance;

  // Decode one byte when the result register can take its result
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  ild_step #(
    .MAX_INSTR_BYTES(MAX_INSTR_BYTES)
  ) u_step (
    .state     (state_r),
    .code_byte (in_code_byte_r),
    .long_mode (long_mode_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      long_mode_r <= cfg_wr_data;
    end
  end

  // Byte register: load on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_code_byte_r <= in_code_byte;
    end
  end

  // Decode state: advance once per decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ild_pkg::STATE_CLEAR;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register: load on a finished instruction, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && step_res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      out_instr_length_r <= step_res.instr_length;
      out_overlong_r     <= step_res.overlong;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_instr_length = out_instr_length_r;
  assign out_overlong     = out_overlong_r;

endmodule

### sv/ild_checker.sv
module ild_checker #(
  parameter int unsigned MAX_INSTR_BYTES = ild_pkg::MAX_INSTR_BYTES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_instr_length,
  input logic       out_overlong
);

  localparam logic [3:0] MAX_LEN = 4'(MAX_INSTR_BYTES);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_instr_length) &&
                                $stable(out_overlong))
    else $error("stalled result changed");

  // Clear the result side on reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Report no empty instruction
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_instr_length != 4'd0)
    else $error("zero instruction length");

  // Keep lengths within the limit
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_instr_length <= MAX_LEN)
    else $error("instruction length above limit");

  // Cut instructions carry exactly the limit
  a_overlong_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overlong |-> out_instr_length == MAX_LEN)
    else $error("overlong result with wrong length");

endmodule

bind x86_instruction_length_decoder_core ild_checker #(
  .MAX_INSTR_BYTES(MAX_INSTR_BYTES)
) u_ild_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_instr_length (out_instr_length),
  .out_overlong     (out_overlong)
);

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int CFG_SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 6;
  localparam int BYTES_PER_PHASE = 150;

  // ModRM mod codes that the package leaves unnamed
  localparam logic [1:0] MOD_DISP8 = 2'b01;
  localparam logic [1:0] MOD_WIDE = 2'b10;

  // Predicts instruction lengths from the byte stream and holds them until they come out
  class length_scoreboard;
    typedef struct packed {
      logic [3:0] len;
      logic       ovl;
    } length_t;

    bit              long_mode;
    ild_pkg::phase_t ph;
    bit              op16;
    bit              op64;
    bit              ad16;
    logic [3:0]      count;
    logic [3:0]      skip;
    logic [2:0]      imm_code;
    logic [7:0]      held;
    length_t         pending[$];
    int              errors;

    function new();
      long_mode = 1'b0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph = ild_pkg::PH_OPCODE;
      op16 = 1'b0;
      op64 = 1'b0;
      ad16 = 1'b0;
      count = '0;
      skip = '0;
      imm_code = '0;
      held = '0;
    endfunction

    function int iz_bytes();
      return (op16 && !op64) ? 2 : 4;
    endfunction

    function int iv_bytes();
      if (op64) return 8;
      return op16 ? 2 : 4;
    endfunction

    function int moffs_bytes();
      if (long_mode) return ad16 ? 4 : 8;
      return ad16 ? 2 : 4;
    endfunction

    function bit to_modrm(int imm);
      imm_code = 3'(imm);
      ph = ild_pkg::PH_MODRM;
      return 1'b0;
    endfunction

    function bit to_tail(int rem);
      if (rem == 0) return 1'b1;
      skip = 4'(rem);
      ph = ild_pkg::PH_TAIL;
      return 1'b0;
    endfunction

    // Prefixes stay in this phase; an opcode moves on or ends the instruction
    function bit opcode_byte(logic [7:0] b);
      held = b;
      if (b == ild_pkg::OPC_ESC) begin
        ph = ild_pkg::PH_MAP0F;
        return 1'b0;
      end
      if (b == ild_pkg::OPC_OPSIZE) begin
        op16 = 1'b1;
        return 1'b0;
      end
      if (b == ild_pkg::OPC_ADSIZE) begin
        ad16 = 1'b1;
        return 1'b0;
      end
      if (b inside {8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'hF2, 8'hF3}) return 1'b0;
      if (long_mode && b inside {[8'h40:8'h4F]}) begin
        if (b[3]) op64 = 1'b1;
        return 1'b0;
      end
      if (b == ild_pkg::OPC_VEX3 || b == ild_pkg::OPC_VEX2) begin
        if (!long_mode) return to_modrm(0);
        skip = (b == ild_pkg::OPC_VEX3) ? 4'd2 : 4'd1;
        ph = ild_pkg::PH_VEX;
        return 1'b0;
      end
      if (b < 8'h40) begin
        if (b[2:0] <= 3'd3) return to_modrm(0);
        if (b[2:0] == 3'd4) return to_tail(1);
        if (b[2:0] == 3'd5) return to_tail(iz_bytes());
        return 1'b1;
      end
      if (b inside {8'h62, 8'h63, [8'h84:8'h8F], [8'hD0:8'hD3], 8'hFE, 8'hFF})
        return to_modrm(0);
      if (b inside {8'h6A, [8'h70:8'h7F], 8'hA8, [8'hB0:8'hB7], 8'hCD, 8'hD4, 8'hD5,
                    [8'hE0:8'hE7], 8'hEB})
        return to_tail(1);
      if (b inside {8'h68, 8'hA9, 8'hE8, 8'hE9}) return to_tail(iz_bytes());
      if (b inside {8'h69, 8'h81, 8'hC7}) return to_modrm(iz_bytes());
      if (b inside {8'h6B, 8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6}) return to_modrm(1);
      if (b inside {[8'hA0:8'hA3]}) return to_tail(moffs_bytes());
      if (b inside {[8'hB8:8'hBF]}) return to_tail(iv_bytes());
      if (b inside {8'hC2, 8'hCA}) return to_tail(2);
      if (b == 8'hC8) return to_tail(3);
      if (b inside {8'h9A, 8'hEA}) return to_tail(2 + iz_bytes());
      if (b == ild_pkg::OPC_GRP3B) return to_modrm(ild_pkg::IMM_TEST_B);
      if (b == ild_pkg::OPC_GRP3Z) return to_modrm(ild_pkg::IMM_TEST_Z);
      return 1'b1;
    endfunction

    function bit map0f_byte(logic [7:0] b);
      held = b;
      if (b == ild_pkg::OPC_ESC38) begin
        ph = ild_pkg::PH_MAP38;
        return 1'b0;
      end
      if (b == ild_pkg::OPC_ESC3A) begin
        ph = ild_pkg::PH_MAP3A;
        return 1'b0;
      end
      if (b inside {[8'h80:8'h8F]}) return to_tail(iz_bytes());
      if (b inside {[8'h70:8'h73], 8'hA4, 8'hAC, 8'hBA, 8'hC2, [8'hC4:8'hC6]})
        return to_modrm(1);
      if (b inside {[8'h00:8'h03], 8'h0D, [8'h10:8'h18], 8'h1A, 8'h1B, 8'h1F,
                    [8'h20:8'h23], [8'h28:8'h2F], [8'h40:8'h6F], [8'h74:8'h76], 8'h78,
                    8'h79, [8'h7C:8'h7F], [8'h90:8'h9F], 8'hA3, 8'hA5, [8'hAB:8'hAF],
                    [8'hB0:8'hB8], [8'hBB:8'hBF], 8'hC0, 8'hC1, 8'hC3, 8'hC7,
                    [8'hD0:8'hFE]})
        return to_modrm(0);
      return 1'b1;
    endfunction

    function bit map38_byte(logic [7:0] b);
      held = b;
      if (b inside {8'h10, 8'h13}) return to_modrm(1);
      if (b inside {[8'h00:8'h0F], [8'h14:8'h1A], [8'h1C:8'h1E], [8'h20:8'h25],
                    [8'h28:8'h41], [8'h45:8'h47], [8'h58:8'h5A], 8'h78, 8'h79,
                    [8'h80:8'h82], 8'h8C, 8'h8E, [8'h90:8'h93], [8'h96:8'h9F],
                    [8'hA6:8'hAF], [8'hB6:8'hBF], [8'hC8:8'hCD], [8'hDB:8'hDF],
                    [8'hF0:8'hF3], [8'hF5:8'hF7]})
        return to_modrm(0);
      return 1'b1;
    endfunction

    function bit map3a_byte(logic [7:0] b);
      held = b;
      if (b inside {[8'h00:8'h02], [8'h04:8'h06], [8'h08:8'h0F], [8'h14:8'h19], 8'h1D,
                    [8'h20:8'h22], 8'h38, 8'h39, [8'h40:8'h42], 8'h44, 8'h46,
                    [8'h4A:8'h4C], [8'h60:8'h63], 8'hCC, 8'hDF, 8'hF0})
        return to_modrm(1);
      return 1'b1;
    endfunction

    // Resolve the group F6/F7 immediate, then count displacement bytes
    function bit modrm_byte(logic [7:0] b);
      logic [1:0] md;
      logic [2:0] rg;
      logic [2:0] rmv;
      int imm;
      int disp;
      md = b[7:6];
      rg = b[5:3];
      rmv = b[2:0];
      imm = imm_code;
      disp = 0;
      if (imm_code == ild_pkg::IMM_TEST_B) imm = (rg == 3'd0) ? 1 : 0;
      else if (imm_code == ild_pkg::IMM_TEST_Z) imm = (rg == 3'd0) ? iz_bytes() : 0;
      else if (imm > 4) imm = 0;
      held = b;
      if (md == ild_pkg::MOD_REG) return to_tail(imm);
      if (!long_mode && ad16) begin
        if (md == MOD_DISP8) disp = 1;
        else if (md == MOD_WIDE || rmv == ild_pkg::RM_DISP16) disp = 2;
        return to_tail(disp + imm);
      end
      if (md == MOD_DISP8) disp = 1;
      else if (md == MOD_WIDE || rmv == ild_pkg::RM_DISP32) disp = 4;
      if (rmv == ild_pkg::RM_SIB) begin
        skip = 4'(disp + imm);
        ph = ild_pkg::PH_SIB;
        return 1'b0;
      end
      return to_tail(disp + imm);
    endfunction

    // Advance the decode by one accepted byte and queue a length when it ends
    function void note_byte(logic [7:0] b);
      int n;
      int rem;
      bit done;
      length_t got;
      n = count + 1;
      done = 1'b0;
      case (ph)
        ild_pkg::PH_OPCODE: done = opcode_byte(b);
        ild_pkg::PH_VEX: begin
          if (skip <= 4'd1) begin
            skip = '0;
            ph = ild_pkg::PH_OPCODE;
          end else skip--;
        end
        ild_pkg::PH_MAP0F: done = map0f_byte(b);
        ild_pkg::PH_MAP38: done = map38_byte(b);
        ild_pkg::PH_MAP3A: done = map3a_byte(b);
        ild_pkg::PH_MODRM: done = modrm_byte(b);
        ild_pkg::PH_SIB: begin
          rem = skip;
          if (held[7:6] == 2'b00 && b[2:0] == ild_pkg::RM_DISP32) rem += 4;
          done = to_tail(rem);
        end
        default: begin
          if (skip <= 4'd1) done = 1'b1;
          else skip--;
        end
      endcase
      if (done) begin
        got.len = 4'(n);
        got.ovl = 1'b0;
        pending.push_back(got);
        clear();
      end else if (n >= ild_pkg::MAX_INSTR_BYTES_DEF) begin
        got.len = 4'(ild_pkg::MAX_INSTR_BYTES_DEF);
        got.ovl = 1'b1;
        pending.push_back(got);
        clear();
      end else begin
        count = 4'(n);
      end
    endfunction

    function void check_length(logic [3:0] len, logic ovl);
      length_t want;
      if (pending.size() == 0) begin
        $display("%0t: length %0d overlong %0b with no instruction pending", $time, len, ovl);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (len !== want.len) begin
        $display("%0t: instr_length expected %0d actual %0d", $time, want.len, len);
        errors++;
      end
      if (ovl !== want.ovl) begin
        $display("%0t: overlong expected %0b actual %0b", $time, want.ovl, ovl);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_code_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [3:0] out_instr_length;
  logic       out_overlong;

  length_scoreboard sb;
  int  prefix_run = 0;
  int  out_hold = 0;
  int  quiet_cycles = 0;
  bit  in_steady = 1'b0;
  bit  out_steady = 1'b0;

  logic [7:0] hot_opcodes[$] = '{
    8'h00, 8'h03, 8'h04, 8'h05, 8'h62, 8'h68, 8'h69, 8'h6A, 8'h6B, 8'h74, 8'h80,
    8'h81, 8'h83, 8'h89, 8'h8B, 8'h8D, 8'h90, 8'h9A, 8'hA0, 8'hA1, 8'hA2, 8'hA3,
    8'hA8, 8'hA9, 8'hB0, 8'hB8, 8'hBF, 8'hC0, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6,
    8'hC7, 8'hC8, 8'hCA, 8'hCD, 8'hD1, 8'hD4, 8'hE8, 8'hE9, 8'hEA, 8'hEB, 8'hF0,
    8'hF6, 8'hF7, 8'hFE, 8'hFF
  };

  // 32-bit mode: operand and address size, SIB, group F6/F7, maps, VEX as ModRM, limit
  logic [7:0] legacy_seq[$] = '{
    8'h90,
    8'h05, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h66, 8'h05, 8'h00, 8'h80,
    8'h67, 8'h8B, 8'h46, 8'h10,
    8'h67, 8'h8B, 8'h06, 8'h34, 8'h12,
    8'h8B, 8'h04, 8'h25, 8'h78, 8'h56, 8'h34, 8'h12,
    8'hF6, 8'hC0, 8'hFF,
    8'hF6, 8'hD0,
    8'h66, 8'hF7, 8'hC0, 8'h01, 8'h02,
    8'hC8, 8'h10, 8'h00, 8'h01,
    8'h67, 8'hA1, 8'h34, 8'h12,
    8'h0F, 8'h3A, 8'h0F, 8'hC0, 8'h08,
    8'h0F, 8'h38, 8'hF4,
    8'h0F, 8'h84, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hC4, 8'hC0,
    8'h9A, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
    8'hF0, 8'h40,
    8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66,
    8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66,
    8'h26, 8'h26, 8'h26, 8'h26, 8'h26, 8'h26, 8'h26,
    8'h26, 8'h26, 8'h26, 8'h26, 8'h26, 8'h26, 8'h26, 8'h90
  };

  // 64-bit mode: REX.W kept over a later REX, VEX skips, 8-byte moffs, no 16-bit addressing
  logic [7:0] long_seq[$] = '{
    8'hC4, 8'hE2, 8'h79, 8'h18, 8'hC0,
    8'hC5, 8'hF8, 8'h90,
    8'h48, 8'h40, 8'hB8, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
    8'h48, 8'h66, 8'hC7, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hA0, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88,
    8'h67, 8'hA0, 8'h11, 8'h22, 8'h33, 8'h44,
    8'h67, 8'h8B, 8'h06,
    8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F,
    8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F
  };

  x86_instruction_length_decoder_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_byte     (in_code_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_instr_length (out_instr_length),
    .out_overlong     (out_overlong)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] any_prefix();
    if (sb.long_mode && $urandom_range(0, 2) == 0) return 8'h40 | 8'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0: return 8'h26;
      1: return 8'h2E;
      2: return 8'h36;
      3: return 8'h3E;
      4: return 8'h64;
      5: return 8'h65;
      6: return 8'hF2;
      7: return 8'hF3;
      8: return ild_pkg::OPC_OPSIZE;
      default: return ild_pkg::OPC_ADSIZE;
    endcase
  endfunction

  // Steer the stream toward well-formed instructions, with some noise
  function automatic logic [7:0] next_code_byte();
    int k;
    logic [7:0] r;
    logic [2:0] rmv;
    k = $urandom_range(0, 99);
    r = 8'($urandom);
    if (prefix_run > 0) begin
      prefix_run--;
      return any_prefix();
    end
    if (k < 8) return r;
    case (sb.ph)
      ild_pkg::PH_OPCODE: begin
        if (k < 10) begin
          prefix_run = $urandom_range(13, 15);
          return any_prefix();
        end
        if (k < 30) return any_prefix();
        if (k < 40) return ild_pkg::OPC_ESC;
        return hot_opcodes[$urandom_range(0, hot_opcodes.size() - 1)];
      end
      ild_pkg::PH_MAP0F: begin
        if (k < 25) return ild_pkg::OPC_ESC38;
        if (k < 45) return ild_pkg::OPC_ESC3A;
        return r;
      end
      ild_pkg::PH_MODRM: begin
        if (k < 40) return r;
        case ($urandom_range(0, 3))
          0: rmv = ild_pkg::RM_SIB;
          1: rmv = ild_pkg::RM_DISP32;
          2: rmv = ild_pkg::RM_DISP16;
          default: rmv = r[2:0];
        endcase
        return {r[7:6], (k < 70) ? 3'b000 : r[5:3], rmv};
      end
      ild_pkg::PH_SIB: begin
        if (k < 55) return {r[7:3], ild_pkg::RM_DISP32};
        return r;
      end
      default: return r;
    endcase
  endfunction

  // Offer one request and hold it until accepted, then maybe idle
  task automatic send_byte(input logic [7:0] b);
    int g;
    in_valid <= 1'b1;
    in_code_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    if ($urandom_range(0, 149) == 0) in_steady = !in_steady;
    g = in_steady ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Write long_mode only once the block has drained
  task automatic set_mode(input bit m);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.long_mode = m;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_byte(next_code_byte());
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_mode(1'b0);
    foreach (legacy_seq[i]) send_byte(legacy_seq[i]);
    set_mode(1'b1);
    foreach (long_seq[i]) send_byte(long_seq[i]);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_mode((p == RANDOM_PHASES - 1) ? 1'($urandom_range(0, 1)) : 1'(p % 2));
      send_random(BYTES_PER_PHASE);
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Check each accepted result and stall the result side at random
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_length(out_instr_length, out_overlong);
    if ($urandom_range(0, 299) == 0) out_steady = !out_steady;
    if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!out_steady) out_hold = gap_len();
    end
  end

  // End the run when neither side moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
